@@ rtl/motion_variance_intensity_defines.svh @@
// assertion macros for the motion variance intensity block
`ifndef MOTION_VARIANCE_INTENSITY_DEFINES_SVH
`define MOTION_VARIANCE_INTENSITY_DEFINES_SVH

// same-cycle implication, quiet during reset
`define MVI_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, quiet during reset
`define MVI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/mvi_pkg.sv @@
// shared types and constants for the motion variance intensity block
`timescale 1ns / 1ps
package mvi_pkg;

  localparam int WIN_LOG2 = 6;
  localparam int WIN_LEN = 1 << WIN_LOG2;
  localparam int FILL_W = WIN_LOG2 + 1;
  localparam int MAG_W = 16;
  localparam int SUM_W = MAG_W + WIN_LOG2;
  localparam int SQSUM_W = 2 * MAG_W + WIN_LOG2;
  localparam int DIFF_W = SQSUM_W + WIN_LOG2;
  localparam int GAIN_W = 10;
  localparam int WEIGHT_W = 8;
  localparam int NUM_W = DIFF_W + GAIN_W;
  localparam int DEN_LOG2 = 2 * WIN_LOG2 + 8;
  localparam int SMOOTH_W = 23;
  localparam int METS_W = 20;
  localparam int ENERGY_W = 48;
  localparam int PCT_W = 7;

  localparam logic [SMOOTH_W-1:0] INTENSITY_MAX = SMOOTH_W'(6553600);
  localparam logic [METS_W-1:0] METS_ONE = METS_W'(65536);
  localparam logic [METS_W-1:0] METS_MAX = METS_W'(655360);
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
  localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

  // exact reciprocals for divide by 10 and by 15 on 32-bit values
  localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
  localparam logic [31:0] RECIP15 = 32'h8888_8889;
  localparam int RECIP_SHIFT = 35;

  // energy divide by 28125, two quotient bits per step
  localparam int EDIV_W = 62;
  localparam int EDIV_STEPS = EDIV_W / 2;
  localparam int EREM_W = 15;
  localparam logic [EREM_W+1:0] EDIVISOR1 = 17'd28125;
  localparam logic [EREM_W+1:0] EDIVISOR2 = 17'd56250;
  localparam logic [EREM_W+1:0] EDIVISOR3 = 17'd84375;

  localparam int ROOT_STEPS = MAG_W;

  localparam logic [1:0] CFG_WEIGHT = 2'd0;
  localparam logic [1:0] CFG_GAIN = 2'd1;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLEAR, ST_SQUARE, ST_SUM, ST_ROOT, ST_MSQ, ST_ACC,
    ST_VAR, ST_DIFF, ST_GAIN, ST_SMOOTH, ST_DIV10, ST_FNEW, ST_METS,
    ST_METS2, ST_EMUL1, ST_EMUL2, ST_EDIV, ST_EADD, ST_TIME, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic clear_energy;
    logic square;
    logic sum;
    logic root_step;
    logic msq;
    logic acc;
    logic var_sq;
    logic diff;
    logic gain;
    logic smooth;
    logic div10;
    logic fnew;
    logic mets;
    logic mets2;
    logic emul1;
    logic emul2;
    logic ediv_step;
    logic eadd;
    logic time_upd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic op_clear;
    logic root_last;
    logic will_full;
    logic prev_nonzero;
    logic ediv_last;
  } status_t;

endpackage

@@ rtl/motion_variance_intensity.sv @@
// top level of the motion variance intensity block
`timescale 1ns / 1ps
// One item at a time, one result per item; a new item is taken while the
// previous result still waits in the output register. An energy clear
// skips the arithmetic, a sample before the 64-sample window is full stops
// after the running sums, and a full-window sample skips the energy path
// when the previous timestamp is zero. The result goes valid in the same
// cycle that the block returns to idle and can take the next item. The
// bit-serial square root and the radix-4 divide by 28125 in the energy path
// are the iterative steps. A stalled result holds the block in its final
// state until the output register is free.
module motion_variance_intensity
  import mvi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [GAIN_W-1:0]     cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  operation,
  input  logic signed [15:0]    accel_x,
  input  logic signed [15:0]    accel_y,
  input  logic signed [15:0]    accel_z,
  input  logic [31:0]           time_ms,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PCT_W-1:0]      intensity_percent,
  output logic [METS_W-1:0]     mets_q16,
  output logic [ENERGY_W-1:0]   energy_total,
  output logic                  window_full
);

  cmd_t cmd;
  status_t status;

  mvi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mvi_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .operation         (operation),
    .accel_x           (accel_x),
    .accel_y           (accel_y),
    .accel_z           (accel_z),
    .time_ms           (time_ms),
    .intensity_percent (intensity_percent),
    .mets_q16          (mets_q16),
    .energy_total      (energy_total),
    .window_full       (window_full)
  );

endmodule

@@ rtl/mvi_ctrl.sv @@
// sequencing controller for the motion variance intensity block
`timescale 1ns / 1ps
module mvi_ctrl
  import mvi_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        // operation is latched by now
        if (status.op_clear) begin
          state_next = ST_CLEAR;
        end else begin
          cmd.square = 1'b1;
          state_next = ST_SUM;
        end
      end
      ST_CLEAR: begin
        cmd.clear_energy = 1'b1;
        state_next = ST_DONE;
      end
      ST_SUM: begin
        cmd.sum = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_last) state_next = ST_MSQ;
      end
      ST_MSQ: begin
        cmd.msq = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        state_next = status.will_full ? ST_VAR : ST_DONE;
      end
      ST_VAR: begin
        cmd.var_sq = 1'b1;
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff = 1'b1;
        state_next = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.gain = 1'b1;
        state_next = ST_SMOOTH;
      end
      ST_SMOOTH: begin
        cmd.smooth = 1'b1;
        state_next = ST_DIV10;
      end
      ST_DIV10: begin
        cmd.div10 = 1'b1;
        state_next = ST_FNEW;
      end
      ST_FNEW: begin
        cmd.fnew = 1'b1;
        state_next = ST_METS;
      end
      ST_METS: begin
        cmd.mets = 1'b1;
        state_next = ST_METS2;
      end
      ST_METS2: begin
        cmd.mets2 = 1'b1;
        state_next = status.prev_nonzero ? ST_EMUL1 : ST_TIME;
      end
      ST_EMUL1: begin
        cmd.emul1 = 1'b1;
        state_next = ST_EMUL2;
      end
      ST_EMUL2: begin
        cmd.emul2 = 1'b1;
        state_next = ST_EDIV;
      end
      ST_EDIV: begin
        cmd.ediv_step = 1'b1;
        if (status.ediv_last) state_next = ST_EADD;
      end
      ST_EADD: begin
        cmd.eadd = 1'b1;
        state_next = ST_TIME;
      end
      ST_TIME: begin
        cmd.time_upd = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // wait until the output register is free or being emptied
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          out_valid_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/mvi_datapath.sv @@
// datapath: magnitude ring, running sums, intensity, mets and energy
`timescale 1ns / 1ps
module mvi_datapath
  import mvi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [GAIN_W-1:0]     cfg_data,
  input  logic                  operation,
  input  logic signed [15:0]    accel_x,
  input  logic signed [15:0]    accel_y,
  input  logic signed [15:0]    accel_z,
  input  logic [31:0]           time_ms,
  output logic [PCT_W-1:0]      intensity_percent,
  output logic [METS_W-1:0]     mets_q16,
  output logic [ENERGY_W-1:0]   energy_total,
  output logic                  window_full
);

  // configuration
  logic [WEIGHT_W-1:0] body_weight;
  logic [GAIN_W-1:0] gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      body_weight <= WEIGHT_W'(65);
      gain <= GAIN_W'(200);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_WEIGHT: body_weight <= cfg_data[WEIGHT_W-1:0];
        CFG_GAIN: gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched item
  logic op;
  logic signed [15:0] ax, ay, az;
  logic [31:0] now;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= operation;
      ax <= accel_x;
      ay <= accel_y;
      az <= accel_z;
      now <= time_ms;
    end
  end

  // squares and root
  logic [30:0] px, py, pz;
  logic signed [31:0] sx, sy, sz;
  logic [31:0] root_src;
  logic [MAG_W+1:0] root_rem;
  logic [MAG_W-1:0] root;
  logic [3:0] root_cnt;
  logic [MAG_W+3:0] rem_sh, trial;

  assign sx = ax * ax;
  assign sy = ay * ay;
  assign sz = az * az;
  assign rem_sh = {root_rem, root_src[31:30]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      px <= sx[30:0];
      py <= sy[30:0];
      pz <= sz[30:0];
    end
    if (cmd.sum) begin
      root_src <= 32'(px) + 32'(py) + 32'(pz);
      root_rem <= '0;
      root <= '0;
      root_cnt <= 4'(ROOT_STEPS - 1);
    end else if (cmd.root_step) begin
      // one result bit per cycle
      root_src <= {root_src[29:0], 2'b00};
      root_cnt <= root_cnt - 4'd1;
      if (rem_sh >= trial) begin
        root_rem <= (MAG_W+2)'(rem_sh - trial);
        root <= {root[MAG_W-2:0], 1'b1};
      end else begin
        root_rem <= rem_sh[MAG_W+1:0];
        root <= {root[MAG_W-2:0], 1'b0};
      end
    end
  end

  // ring and running sums
  logic [MAG_W-1:0] ring [WIN_LEN];
  logic [MAG_W-1:0] old_mag;
  logic [WIN_LOG2-1:0] wp;
  logic [FILL_W-1:0] fill;
  logic [SUM_W-1:0] msum;
  logic [SQSUM_W-1:0] qsum;
  logic [2*MAG_W-1:0] new_sq, old_sq;
  logic full;

  assign full = fill[WIN_LOG2];

  always_ff @(posedge clk) begin
    if (cmd.square) old_mag <= ring[wp];
    if (cmd.msq) ring[wp] <= root;
  end

  always_ff @(posedge clk) begin
    if (cmd.msq) begin
      new_sq <= root * root;
      old_sq <= old_mag * old_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      fill <= '0;
      msum <= '0;
      qsum <= '0;
    end else if (cmd.acc) begin
      wp <= wp + 1'b1;
      if (!full) fill <= fill + 1'b1;
      if (full) begin
        msum <= msum - SUM_W'(old_mag) + SUM_W'(root);
        qsum <= qsum - SQSUM_W'(old_sq) + SQSUM_W'(new_sq);
      end else begin
        msum <= msum + SUM_W'(root);
        qsum <= qsum + SQSUM_W'(new_sq);
      end
    end
  end

  // variance to smoothed intensity and mets
  localparam logic [NUM_W-1:0] NUM_CLAMP = NUM_W'(INTENSITY_MAX) << DEN_LOG2;
  logic [DIFF_W-1:0] ss, q64, dvar;
  logic [NUM_W-1:0] num;
  logic [SMOOTH_W-1:0] inten;
  logic [25:0] sm_num;
  logic [57:0] prod10;
  logic [55:0] prod15;
  logic [SMOOTH_W-1:0] fsm;
  logic [METS_W-1:0] mets;
  logic [20:0] mets_raw;

  assign inten = (num >= NUM_CLAMP) ? INTENSITY_MAX : num[DEN_LOG2 +: SMOOTH_W];
  assign mets_raw = 21'(METS_ONE) + prod15[RECIP_SHIFT +: 21];

  always_ff @(posedge clk) begin
    if (cmd.var_sq) begin
      ss <= msum * msum;
      q64 <= {qsum, {WIN_LOG2{1'b0}}};
    end
    if (cmd.diff) dvar <= q64 - ss;
    if (cmd.gain) num <= dvar * gain;
    if (cmd.smooth) sm_num <= 26'(fsm) * 26'd9 + 26'(inten) + 26'd5;
    if (cmd.div10) prod10 <= sm_num * RECIP10;
    if (cmd.mets) prod15 <= (24'(fsm) + 24'd7) * RECIP15;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= '0;
      mets <= METS_ONE;
    end else begin
      if (cmd.fnew) fsm <= prod10[RECIP_SHIFT +: SMOOTH_W];
      if (cmd.mets2) mets <= (mets_raw > 21'(METS_MAX)) ? METS_MAX : mets_raw[METS_W-1:0];
    end
  end

  // energy: mets * weight * dt * 2 / 28125
  logic [31:0] prev_time;
  logic [27:0] mw;
  logic [31:0] dt;
  logic [EDIV_W-1:0] eshift;
  logic [EDIV_W-1:0] equot;
  logic [EREM_W-1:0] erem;
  logic [4:0] ediv_cnt;
  logic [EREM_W+1:0] erem4;
  logic [ENERGY_W-1:0] energy;
  logic [ENERGY_W:0] esum;
  logic [59:0] mwdt;

  assign erem4 = {erem, eshift[EDIV_W-1:EDIV_W-2]};
  assign esum = {1'b0, energy} + {1'b0, equot[ENERGY_W-1:0]};
  assign mwdt = mw * dt;

  always_ff @(posedge clk) begin
    if (cmd.emul1) begin
      mw <= mets * body_weight;
      dt <= now - prev_time;
    end
    if (cmd.emul2) begin
      eshift <= EDIV_W'({mwdt, 1'b0});
      equot <= '0;
      erem <= '0;
      ediv_cnt <= 5'(EDIV_STEPS - 1);
    end else if (cmd.ediv_step) begin
      eshift <= {eshift[EDIV_W-3:0], 2'b00};
      ediv_cnt <= ediv_cnt - 5'd1;
      if (erem4 >= EDIVISOR3) begin
        erem <= EREM_W'(erem4 - EDIVISOR3);
        equot <= {equot[EDIV_W-3:0], 2'd3};
      end else if (erem4 >= EDIVISOR2) begin
        erem <= EREM_W'(erem4 - EDIVISOR2);
        equot <= {equot[EDIV_W-3:0], 2'd2};
      end else if (erem4 >= EDIVISOR1) begin
        erem <= EREM_W'(erem4 - EDIVISOR1);
        equot <= {equot[EDIV_W-3:0], 2'd1};
      end else begin
        erem <= erem4[EREM_W-1:0];
        equot <= {equot[EDIV_W-3:0], 2'd0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      energy <= '0;
      prev_time <= '0;
    end else begin
      if (cmd.clear_energy) energy <= '0;
      else if (cmd.eadd) energy <= esum[ENERGY_W] ? ENERGY_MAX : esum[ENERGY_W-1:0];
      if (cmd.time_upd) prev_time <= now;
    end
  end

  // status back to the controller
  assign status.op_clear = (op == OP_CLEAR);
  assign status.root_last = (root_cnt == 4'd0);
  assign status.will_full = full || (&fill[WIN_LOG2-1:0]);
  assign status.prev_nonzero = (prev_time != 32'd0);
  assign status.ediv_last = (ediv_cnt == 5'd0);

  // output register
  logic [23:0] pct_sum;
  assign pct_sum = 24'(fsm) + 24'd32768;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      intensity_percent <= (pct_sum[23:16] > 8'(PCT_MAX)) ? PCT_MAX : pct_sum[22:16];
      mets_q16 <= mets;
      energy_total <= energy;
      window_full <= full;
    end
  end

endmodule

@@ rtl/mvi_checker.sv @@
// port-level checks for the motion variance intensity block
`timescale 1ns / 1ps
`include "motion_variance_intensity_defines.svh"
module mvi_checker
  import mvi_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [PCT_W-1:0]    intensity_percent,
  input logic [METS_W-1:0]   mets_q16
);

  `MVI_ASSERT_NEXT(a_out_held, clk, rst, out_valid && out_stall, out_valid)
  `MVI_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && !in_stall, in_stall)
  `MVI_ASSERT_NOW(a_pct_range, clk, rst, out_valid, intensity_percent <= PCT_MAX)
  `MVI_ASSERT_NOW(a_mets_range, clk, rst, out_valid, mets_q16 >= METS_ONE && mets_q16 <= METS_MAX)

endmodule

bind motion_variance_intensity mvi_checker u_chk (.*);
